// File: hdl/mnsq_pkg.sv
// ----------------------------------------------------------------------------
// mnsq_pkg
// Shared types, constants and helpers for the multi-node stack/queue engine.
// ----------------------------------------------------------------------------
package mnsq_pkg;

   localparam int NUM_NODES   = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int STACK_DEPTH = 16;

   localparam int NODE_W  = 3;
   localparam int CAP_W   = 5;
   localparam int CNT_W   = 4;
   localparam int CAPS_W  = 40;
   localparam int BYTE_W  = 8;
   localparam int FIFO_SLOTS = QUEUE_DEPTH + 1;
   localparam int FIFO_MEM_DEPTH  = NUM_NODES * FIFO_SLOTS;
   localparam int STACK_MEM_DEPTH = NUM_NODES * STACK_DEPTH;
   localparam int FIFO_AW  = $clog2(FIFO_MEM_DEPTH);
   localparam int STACK_AW = $clog2(STACK_MEM_DEPTH);
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      CMD_ADD_QUEUE = 2'd0,
      CMD_ADD_STACK = 2'd1,
      CMD_SEND      = 2'd2,
      CMD_OPERATE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_QUEUE_FULL = 2'd1,
      KIND_STACK_FULL = 2'd2,
      KIND_EMPTY      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_NODE_COUNT = 2'd0,
      CSR_QUEUE_CAPS = 2'd1,
      CSR_STACK_CAPS = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAKE,
      ST_PUT,
      ST_OUT1,
      ST_OUT2
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic latch;   // capture request, decode
      logic take;    // perform add or take on target node, access memory
      logic put;     // put taken byte into server FIFO
      logic out1;    // first result presented
      logic out2;    // second result presented
   } ctrl_type;

   // Datapath to controller.
   typedef struct packed {
      logic no_result;  // command ends with nothing to report
      logic is_send;    // send with a byte taken: server put follows
      logic two_results;
   } stat_type;

   typedef struct packed {
      logic [NODE_W-1:0] log_node;
      kind_type          entry_kind;
      logic [BYTE_W-1:0] entry_value;
      logic              last;
   } rsp_type;

   function automatic logic [CAP_W-1:0] cap_sel(input logic [CAPS_W-1:0] caps,
                                                input logic [NODE_W-1:0] n,
                                                input logic [CAP_W-1:0] depth);
      logic [CAP_W-1:0] c;
      c = caps[n*CAP_W +: CAP_W];
      return (c > depth) ? depth : c;
   endfunction

endpackage

// File: hdl/mnsq_if.sv
// ----------------------------------------------------------------------------
// mnsq channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface mnsq_req_if;
   logic                          valid;
   logic                          ready;
   mnsq_pkg::cmd_type             cmd;
   logic [mnsq_pkg::NODE_W-1:0]   node;
   logic [mnsq_pkg::BYTE_W-1:0]   value;
   modport source (output valid, cmd, node, value, input ready);
   modport sink   (input valid, cmd, node, value, output ready);
endinterface

interface mnsq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mnsq_pkg::NODE_W-1:0]   log_node;
   mnsq_pkg::kind_type            entry_kind;
   logic [mnsq_pkg::BYTE_W-1:0]   entry_value;
   logic                          last;
   modport source (output valid, log_node, entry_kind, entry_value, last, input ready);
   modport sink   (input valid, log_node, entry_kind, entry_value, last, output ready);
endinterface

interface mnsq_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mnsq_pkg::CSR_IDX_W-1:0]   index;
   logic [mnsq_pkg::CAPS_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/mnsq_ram.sv
// ----------------------------------------------------------------------------
// mnsq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mnsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// File: hdl/mnsq_ctrl.sv
// ----------------------------------------------------------------------------
// mnsq_ctrl
// Sequencer for one command: take, server put for a send, then no, one or two results.
// ----------------------------------------------------------------------------
module mnsq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  mnsq_pkg::stat_type  stat,
   output mnsq_pkg::ctrl_type  ctrl
);
   import mnsq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // No transfer is taken while reset is held.
            req_ready  = !reset;
            ctrl.latch = req_valid && !reset;
            if (req_valid && !reset) begin
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            ctrl.take = 1'b1;
            priority if (stat.no_result) begin
               state_in = ST_IDLE;
            end else if (stat.is_send) begin
               state_in = ST_PUT;
            end else begin
               state_in = ST_OUT1;
            end
         end
         ST_PUT: begin
            ctrl.put = 1'b1;
            state_in = ST_OUT1;
         end
         ST_OUT1: begin
            ctrl.out1 = 1'b1;
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = stat.two_results ? ST_OUT2 : ST_IDLE;
            end
         end
         ST_OUT2: begin
            ctrl.out2 = 1'b1;
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// File: hdl/mnsq_dp.sv
// ----------------------------------------------------------------------------
// mnsq_dp
// Datapath: configuration, per-node pointers, FIFO and stack memories.
// ----------------------------------------------------------------------------
module mnsq_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  mnsq_pkg::ctrl_type               ctrl,
   output mnsq_pkg::stat_type               stat,
   input  mnsq_pkg::cmd_type                req_cmd,
   input  logic [mnsq_pkg::NODE_W-1:0]      req_node,
   input  logic [mnsq_pkg::BYTE_W-1:0]      req_value,
   input  logic                             csr_we,
   input  logic [mnsq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mnsq_pkg::CAPS_W-1:0]      csr_data,
   output mnsq_pkg::rsp_type                rsp
);
   import mnsq_pkg::*;

   localparam logic [CAP_W-1:0] QDEPTH = CAP_W'(QUEUE_DEPTH);
   localparam logic [CAP_W-1:0] SDEPTH = CAP_W'(STACK_DEPTH);

   logic [CNT_W-1:0]  cnt_ff;
   logic [CAPS_W-1:0] qcaps_ff, scaps_ff;
   logic [CAP_W-1:0]  head_ff  [NUM_NODES];
   logic [CAP_W-1:0]  tail_ff  [NUM_NODES];
   logic [CAP_W-1:0]  level_ff [NUM_NODES];

   cmd_type           cmd_ff;
   logic [NODE_W-1:0] node_ff, server_ff;
   logic [BYTE_W-1:0] value_ff;
   logic              ignore_ff;
   // results
   kind_type          kind1_ff;
   logic              r2_ff, from_stack_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= CNT_W'(NUM_NODES);
         qcaps_ff <= '0;
         scaps_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT: cnt_ff   <= csr_data[CNT_W-1:0];
            CSR_QUEUE_CAPS: qcaps_ff <= csr_data;
            CSR_STACK_CAPS: scaps_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Nodes in use, clamped; the server is the last one.
   logic [CNT_W-1:0] used;
   always_comb begin
      used = cnt_ff;
      if (used == '0) used = CNT_W'(1);
      if (used > CNT_W'(NUM_NODES)) used = CNT_W'(NUM_NODES);
   end

   function automatic logic [CAP_W-1:0] nslot(input logic [CAP_W-1:0] cap,
                                              input logic [CAP_W-1:0] x);
      logic [CAP_W:0] y;
      y = {1'b0, x} + 1'b1;
      return (y >= ({1'b0, cap} + 1'b1)) ? '0 : y[CAP_W-1:0];
   endfunction

   // Operating node for the take phase, and the server for the put phase.
   logic [NODE_W-1:0] tn;
   logic [CAP_W-1:0]  qcap_t, scap_t, qcap_s, nt_t, nh_t, nt_s;
   logic              st_nonempty, q_nonempty, q_full_t, q_full_s, s_full;
   logic [CAP_W-1:0]  lv_dec;

   assign tn     = (cmd_ff == CMD_OPERATE) ? server_ff : node_ff;
   assign qcap_t = cap_sel(qcaps_ff, tn, QDEPTH);
   assign scap_t = cap_sel(scaps_ff, tn, SDEPTH);
   assign qcap_s = cap_sel(qcaps_ff, server_ff, QDEPTH);
   assign nt_t   = nslot(qcap_t, tail_ff[tn]);
   assign nh_t   = nslot(qcap_t, head_ff[tn]);
   assign nt_s   = nslot(qcap_s, tail_ff[server_ff]);
   assign st_nonempty = level_ff[tn] != '0;
   assign q_nonempty  = head_ff[tn] != tail_ff[tn];
   assign q_full_t    = nt_t == head_ff[tn];
   assign q_full_s    = nt_s == head_ff[server_ff];
   assign s_full      = level_ff[tn] >= scap_t;
   assign lv_dec      = (level_ff[tn] - 1'b1 >= SDEPTH) ? SDEPTH - 1'b1
                                                        : level_ff[tn] - 1'b1;

   logic took;
   assign took = st_nonempty || q_nonempty;

   // Memory ports.
   logic              f_we, s_we;
   logic [FIFO_AW-1:0]  f_addr;
   logic [STACK_AW-1:0] s_addr;
   logic [BYTE_W-1:0]   f_wdata, f_rdata, s_rdata;

   always_comb begin
      f_we    = 1'b0;
      s_we    = 1'b0;
      f_addr  = FIFO_AW'(tn * FIFO_SLOTS + nh_t);
      s_addr  = STACK_AW'(tn * STACK_DEPTH + lv_dec);
      f_wdata = value_ff;
      if (ctrl.take && !ignore_ff) begin
         unique case (cmd_ff)
            CMD_ADD_QUEUE: begin
               f_we   = !q_full_t;
               f_addr = FIFO_AW'(tn * FIFO_SLOTS + nt_t);
            end
            CMD_ADD_STACK: begin
               s_we   = !s_full;
               s_addr = STACK_AW'(tn * STACK_DEPTH + level_ff[tn]);
            end
            default: ;
         endcase
      end
      if (ctrl.put) begin
         f_we    = !q_full_s;
         f_addr  = FIFO_AW'(server_ff * FIFO_SLOTS + nt_s);
         f_wdata = from_stack_ff ? s_rdata : f_rdata;
      end
   end

   mnsq_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_MEM_DEPTH)) u_fifo_ram (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
   );
   mnsq_ram #(.WIDTH(BYTE_W), .DEPTH(STACK_MEM_DEPTH)) u_stack_ram (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(value_ff), .rdata(s_rdata)
   );

   // Byte delivered is captured at the put or at the first output cycle.
   logic [BYTE_W-1:0] byte_ff;
   logic              byte_ok_ff;

   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         cmd_ff    <= req_cmd;
         node_ff   <= req_node;
         value_ff  <= req_value;
         server_ff <= NODE_W'(used - 1'b1);
         ignore_ff <= (req_cmd != CMD_OPERATE) && ({1'b0, req_node} >= used);
         byte_ok_ff <= 1'b0;
      end
      if (ctrl.take) begin
         from_stack_ff <= st_nonempty;
         r2_ff         <= 1'b0;
         unique case (cmd_ff)
            CMD_ADD_QUEUE: kind1_ff <= KIND_QUEUE_FULL;
            CMD_ADD_STACK: kind1_ff <= KIND_STACK_FULL;
            default:       kind1_ff <= took ? KIND_BYTE : KIND_EMPTY;
         endcase
      end
      if (ctrl.put) begin
         r2_ff      <= q_full_s;
         byte_ff    <= f_wdata;
         byte_ok_ff <= 1'b1;
      end
      if (ctrl.out1 && !byte_ok_ff) begin
         byte_ff    <= from_stack_ff ? s_rdata : f_rdata;
         byte_ok_ff <= 1'b1;
      end
   end

   // Pointer and level updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_NODES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            level_ff[i] <= '0;
         end
      end else begin
         if (ctrl.take && !ignore_ff) begin
            unique case (cmd_ff)
               CMD_ADD_QUEUE: if (!q_full_t) tail_ff[tn] <= nt_t;
               CMD_ADD_STACK: if (!s_full) level_ff[tn] <= level_ff[tn] + 1'b1;
               default: begin
                  if (st_nonempty)     level_ff[tn] <= lv_dec;
                  else if (q_nonempty) head_ff[tn]  <= nh_t;
               end
            endcase
         end
         if (ctrl.put && !q_full_s) begin
            tail_ff[server_ff] <= nt_s;
         end
      end
   end

   always_comb begin
      stat.no_result = 1'b0;
      if (ignore_ff) begin
         stat.no_result = 1'b1;
      end else begin
         unique case (cmd_ff)
            CMD_ADD_QUEUE: stat.no_result = !q_full_t;
            CMD_ADD_STACK: stat.no_result = !s_full;
            default:       stat.no_result = 1'b0;
         endcase
      end
      stat.is_send     = (cmd_ff == CMD_SEND) && took;
      stat.two_results = r2_ff;
   end

   logic [BYTE_W-1:0] cur_byte;
   assign cur_byte = byte_ok_ff ? byte_ff : (from_stack_ff ? s_rdata : f_rdata);

   always_comb begin
      if (ctrl.out2) begin
         rsp.log_node    = server_ff;
         rsp.entry_kind  = KIND_QUEUE_FULL;
         rsp.entry_value = '0;
         rsp.last        = 1'b1;
      end else begin
         rsp.log_node    = tn;
         rsp.entry_kind  = kind1_ff;
         rsp.entry_value = (kind1_ff == KIND_BYTE) ? cur_byte : '0;
         rsp.last        = !r2_ff;
      end
   end
endmodule

// File: hdl/multi_node_stack_queue_engine_core.sv
// ----------------------------------------------------------------------------
// multi_node_stack_queue_engine_core
// Per-node byte FIFOs and stacks with a server node; top level.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                       Transfer
//  req_     in   cmd, node, value                              valid & ready
//  rsp_     out  log_node, entry_kind, entry_value, last       valid & ready
//  csr_     in   index, data                                   valid & ready
//
// A command passes through capture, then memory access, plus a server put
// for a send, which reads the sender's memory and then writes the server's
// FIFO. Each result is then held until the response side takes its transfer.
// Commands with no result free the block after the memory access. Reset is
// synchronous; memories are not cleared and need no clearing pass.
module multi_node_stack_queue_engine_core (
   input logic       clock,
   input logic       reset,
   mnsq_req_if.sink  req,
   mnsq_rsp_if.source rsp,
   mnsq_csr_if.sink  csr
);
   import mnsq_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   rsp_type  rsp_data;

   assign csr.ready = !reset;

   mnsq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .stat(stat), .ctrl(ctrl)
   );

   mnsq_dp u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_cmd(req.cmd), .req_node(req.node), .req_value(req.value),
      .csr_we(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .rsp(rsp_data)
   );

   assign rsp.log_node    = rsp_data.log_node;
   assign rsp.entry_kind  = rsp_data.entry_kind;
   assign rsp.entry_value = rsp_data.entry_value;
   assign rsp.last        = rsp_data.last;
endmodule
